// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/core/fcs_pkg.sv =====
// Types and constants of the counting semaphore with its wait queue.
package fcs_pkg;

  localparam int QUEUE_DEPTH    = 32;
  localparam int THREAD_ID_BITS = 8;

  localparam int ACTION_W   = 2;
  localparam int TID_PORT_W = 8;
  localparam int KIND_W     = 3;
  localparam int COUNT_W    = 16;
  localparam int INIT_W     = 15;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // stored id width: ids are kept to THREAD_ID_BITS and reported in the port width
  localparam int TID_W  = (THREAD_ID_BITS < TID_PORT_W) ? THREAD_ID_BITS : TID_PORT_W;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [QIDX_W-1:0] QIDX_LAST = QIDX_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;

  localparam logic [ACTION_W-1:0] ACT_WAIT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SIGNAL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd2;

  // word index of the configuration registers
  localparam logic REG_INIT_COUNT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROCEED      = 3'd0,
    KIND_BLOCKED      = 3'd1,
    KIND_NO_RELEASE   = 3'd2,
    KIND_RELEASED     = 3'd3,
    KIND_RELEASED_ERR = 3'd4,
    KIND_CLOSE_DONE   = 3'd5,
    KIND_QUEUE_FULL   = 3'd6
  } kind_e;

endpackage

// ===== rtl/core/fifo_counting_semaphore.sv =====
// Counting semaphore with a FIFO wait queue of blocked thread ids.
//
// Input channel (in_valid_i / in_stall_o) carries one word per call: action_i
// (wait, signal, close) and thread_id_i. Output channel (out_valid_o /
// out_stall_i) carries the results: kind_o, released_thread_o, last_o.
// A word is taken in S_IDLE and worked on in S_EXEC once the output register is
// free; a wait or a signal gives one result, and no new word is taken in S_EXEC.
// A close gives one released-with-error result per waiter, one a cycle while the
// receiver keeps up, and then a close-done result. The ids sit in a 32-entry
// synchronous RAM whose registered read is addressed with the next head position.
// The next word is taken while a result still sits in the output register.
// A stalled receiver holds the result and the block waits for it.
// Reset empties the queue and loads the count with zero; initial_count is
// written over the APB port at byte address 0 and is reloaded on every close.
// Action code 3 gives no result.
module fifo_counting_semaphore (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fcs_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fcs_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fcs_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  // calls
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fcs_pkg::ACTION_W-1:0]        action_i,
  input  logic [fcs_pkg::TID_PORT_W-1:0]      thread_id_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fcs_pkg::KIND_W-1:0]          kind_o,
  output logic [fcs_pkg::TID_PORT_W-1:0]      released_thread_o,
  output logic                                last_o
);
  import fcs_pkg::*;

`include "assert_macros.svh"

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                     state_q, state_d;
  logic [ACTION_W-1:0]        act_q;
  logic [TID_W-1:0]           tid_q;
  logic signed [COUNT_W-1:0]  count_q, count_d;
  logic [QIDX_W-1:0]          head_q, head_d;
  logic [QIDX_W-1:0]          tail_q, tail_d;
  logic [QCNT_W-1:0]          used_q, used_d;
  logic [INIT_W-1:0]          init_q;

  logic                       out_valid_q, out_valid_d;
  kind_e                      kind_q, kind_d;
  logic [TID_W-1:0]           rel_q, rel_d;
  logic                       last_q, last_d;

  logic [TID_W-1:0]           mem [QUEUE_DEPTH];
  logic [TID_W-1:0]           rd_q;
  logic                       mem_we;

  logic                       in_take;
  logic                       out_free;
  logic                       load_out;
  logic                       cfg_wr;
  logic [TID_PORT_W-1:0]      rel_ext;

  function automatic logic [QIDX_W-1:0] next_pos(input logic [QIDX_W-1:0] p);
    next_pos = (p == QIDX_LAST) ? '0 : p + 1'b1;
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INIT_COUNT);
  assign prdata = (paddr[2] == REG_INIT_COUNT) ? APB_DATA_W'(init_q) : '0;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    head_d   = head_q;
    tail_d   = tail_q;
    used_d   = used_q;
    mem_we   = 1'b0;
    load_out = 1'b0;
    kind_d   = kind_q;
    rel_d    = '0;
    last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          unique case (act_q)
            ACT_WAIT: begin
              load_out = 1'b1;
              state_d  = S_IDLE;
              if (count_q <= 16'sd0) begin
                if (used_q == QCNT_FULL) begin
                  kind_d = KIND_QUEUE_FULL;
                end else begin
                  mem_we  = 1'b1;
                  tail_d  = next_pos(tail_q);
                  used_d  = used_q + 1'b1;
                  count_d = count_q - 16'sd1;
                  kind_d  = KIND_BLOCKED;
                end
              end else begin
                count_d = count_q - 16'sd1;
                kind_d  = KIND_PROCEED;
              end
            end
            ACT_SIGNAL: begin
              load_out = 1'b1;
              state_d  = S_IDLE;
              kind_d   = KIND_NO_RELEASE;
              if (count_q < COUNT_MAX) begin
                count_d = count_q + 16'sd1;
                // count still at most zero after the increment
                if (count_q < 16'sd0 && used_q != '0) begin
                  kind_d = KIND_RELEASED;
                  rel_d  = rd_q;
                  head_d = next_pos(head_q);
                  used_d = used_q - 1'b1;
                end
              end
            end
            ACT_CLOSE: begin
              load_out = 1'b1;
              if (used_q != '0) begin
                kind_d = KIND_RELEASED_ERR;
                rel_d  = rd_q;
                last_d = 1'b0;
                head_d = next_pos(head_q);
                used_d = used_q - 1'b1;
              end else begin
                kind_d  = KIND_CLOSE_DONE;
                head_d  = '0;
                tail_d  = '0;
                count_d = signed'(COUNT_W'(init_q));
                state_d = S_IDLE;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_WAIT;
      tid_q       <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      init_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_PROCEED;
      rel_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (in_take) begin
        act_q <= action_i;
        tid_q <= thread_id_i[TID_W-1:0];
      end
      if (cfg_wr) begin
        init_q <= pwdata[INIT_W-1:0];
      end
      if (load_out) begin
        kind_q <= kind_d;
        rel_q  <= rel_d;
        last_q <= last_d;
      end
    end
  end

  // wait queue RAM; registered read at the head position of the next cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= tid_q;
    end
    rd_q <= mem[head_d];
  end

  always_comb begin
    rel_ext              = '0;
    rel_ext[TID_W-1:0]   = rel_q;
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign released_thread_o = rel_ext;
  assign last_o            = last_q;

  `ASSERT_NEVER(a_used_bound, clk_i, rst_ni, used_q > QCNT_FULL,
                "wait queue fill above its depth")
  `ASSERT_CLK(a_empty_ptrs, clk_i, rst_ni, (used_q == '0) |-> (head_q == tail_q),
              "empty wait queue with head and tail apart")
  `ASSERT_CLK(a_waiters_neg, clk_i, rst_ni, (used_q != '0) |-> (count_q < 16'sd0),
              "waiters queued while the count is not negative")
  `ASSERT_CLK(a_not_last, clk_i, rst_ni,
              (out_valid_o && !last_o) |-> (kind_q == KIND_RELEASED_ERR),
              "non-final result that is not a close release")

endmodule

// ===== test/tb_fifo_counting_semaphore.sv =====
// Self-checking testbench for the counting semaphore with its FIFO wait queue.
module tb_fifo_counting_semaphore;
  timeunit 1ns;
  timeprecision 1ps;

  import fcs_pkg::*;

  localparam logic [ACTION_W-1:0]   ACT_IGNORED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] INIT_ADDR   = {REG_INIT_COUNT, 2'b00};
  localparam logic [TID_PORT_W-1:0] ID_MASK     = TID_PORT_W'((1 << TID_W) - 1);
  localparam int                    IDLE_LIMIT  = 5000;
  localparam int                    MAX_REPORTS = 10;

  typedef struct {
    logic [ACTION_W-1:0]   action;
    logic [TID_PORT_W-1:0] tid;
  } call_t;

  typedef struct {
    kind_e                 kind;
    logic [TID_PORT_W-1:0] tid;
    logic                  last;
  } sem_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_ADDR_W-1:0]   paddr;
  logic [APB_DATA_W-1:0]   pwdata;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ACTION_W-1:0]     action_i;
  logic [TID_PORT_W-1:0]   thread_id_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [KIND_W-1:0]       kind_o;
  logic [TID_PORT_W-1:0]   released_thread_o;
  logic                    last_o;

  call_t                   pending_calls[$];
  sem_result_t             expected_results[$];
  logic [TID_PORT_W-1:0]   waiters[$];
  int                      sem_count;
  int                      reload_count;
  int                      mismatch_count;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      quiet_cycles;
  logic                    in_taken;

  fifo_counting_semaphore u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .thread_id_i       (thread_id_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .released_thread_o (released_thread_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void expect_result(kind_e kind, logic [TID_PORT_W-1:0] tid, logic last);
    sem_result_t res;
    res.kind = kind;
    res.tid  = tid;
    res.last = last;
    expected_results.push_back(res);
  endfunction

  // Semaphore behaviour for one accepted word.
  function automatic void semaphore_step(logic [ACTION_W-1:0] act,
                                         logic [TID_PORT_W-1:0] tid_in);
    logic [TID_PORT_W-1:0] tid;
    tid = tid_in & ID_MASK;
    case (act)
      ACT_WAIT: begin
        if (sem_count - 1 < 0) begin
          if (waiters.size() >= QUEUE_DEPTH) begin
            expect_result(KIND_QUEUE_FULL, '0, 1'b1);
          end else begin
            waiters.push_back(tid);
            sem_count--;
            expect_result(KIND_BLOCKED, '0, 1'b1);
          end
        end else begin
          sem_count--;
          expect_result(KIND_PROCEED, '0, 1'b1);
        end
      end
      ACT_SIGNAL: begin
        if (sem_count >= int'(COUNT_MAX)) begin
          expect_result(KIND_NO_RELEASE, '0, 1'b1);
        end else begin
          sem_count++;
          if (sem_count <= 0 && waiters.size() > 0) begin
            expect_result(KIND_RELEASED, waiters.pop_front(), 1'b1);
          end else begin
            expect_result(KIND_NO_RELEASE, '0, 1'b1);
          end
        end
      end
      ACT_CLOSE: begin
        while (waiters.size() > 0) begin
          expect_result(KIND_RELEASED_ERR, waiters.pop_front(), 1'b0);
        end
        expect_result(KIND_CLOSE_DONE, '0, 1'b1);
        sem_count = reload_count;
      end
      default: ;
    endcase
  endfunction

  function automatic void add_call(logic [ACTION_W-1:0] act, logic [TID_PORT_W-1:0] tid);
    call_t c;
    c.action = act;
    c.tid    = tid;
    pending_calls.push_back(c);
  endfunction

  function automatic logic [TID_PORT_W-1:0] any_tid();
    return TID_PORT_W'($urandom_range(0, (1 << TID_PORT_W) - 1));
  endfunction

  // Mostly bursts of waits and signals so the queue fills, overflows and drains.
  function automatic void queue_random_calls(int target);
    int made;
    int pick;
    int roll;
    int len;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          add_call(ACT_WAIT, any_tid());
          made++;
        end else if (roll < 85) begin
          add_call(ACT_SIGNAL, any_tid());
          made++;
        end else if (roll < 95) begin
          add_call(ACT_CLOSE, any_tid());
          made++;
        end else begin
          add_call(ACT_IGNORED, any_tid());
        end
      end else if (pick < 7) begin
        len = $urandom_range(8, 36);
        repeat (len) add_call(ACT_WAIT, any_tid());
        made += len;
      end else if (pick < 9) begin
        len = $urandom_range(1, 20);
        repeat (len) add_call(ACT_SIGNAL, any_tid());
        made += len;
      end else begin
        add_call(ACT_CLOSE, any_tid());
        made++;
      end
    end
  endfunction

  // Wait for every word to be taken and every result to arrive, then let the
  // pipeline settle before the next phase.
  task automatic settle();
    while (pending_calls.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_initial_count(logic [INIT_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= INIT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    reload_count = int'(value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DATA_W'(value)) begin
      flag_error($sformatf("initial_count readback: expected %0d, got %0d", value, prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: new word only once the previous one has been taken.
  always @(negedge clk_i) begin
    call_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_calls.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        c = pending_calls.pop_front();
        in_valid_i  <= 1'b1;
        action_i    <= c.action;
        thread_id_i <= c.tid;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor, checker and watchdog.
  always @(posedge clk_i) begin
    sem_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: kind %0d id %0d last %0d",
                               kind_o, released_thread_o, last_o));
        end else begin
          want = expected_results.pop_front();
          if (kind_o !== want.kind) begin
            flag_error($sformatf("kind: expected %0d, got %0d", want.kind, kind_o));
          end
          if (released_thread_o !== want.tid) begin
            flag_error($sformatf("released_thread: expected %0d, got %0d",
                                 want.tid, released_thread_o));
          end
          if (last_o !== want.last) begin
            flag_error($sformatf("last: expected %0d, got %0d", want.last, last_o));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        semaphore_step(action_i, thread_id_i);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("fifo_counting_semaphore verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    in_taken <= in_valid_i && !in_stall_o;
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    action_i       = ACT_WAIT;
    thread_id_i    = '0;
    out_stall_i    = 1'b0;
    in_taken       = 1'b0;
    sem_count      = 0;
    reload_count   = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 19;
    recv_idle_pct  = 79;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // count zero: blocking, release in order, close with and without waiters
    set_initial_count('0);
    add_call(ACT_WAIT, 8'h00);
    add_call(ACT_WAIT, 8'hFF);
    add_call(ACT_WAIT, 8'hAA);
    add_call(ACT_SIGNAL, 8'h01);
    add_call(ACT_IGNORED, 8'h55);
    add_call(ACT_CLOSE, 8'h02);
    add_call(ACT_CLOSE, 8'hFE);
    add_call(ACT_SIGNAL, 8'h80);
    add_call(ACT_WAIT, 8'h12);
    add_call(ACT_WAIT, 8'h34);
    add_call(ACT_WAIT, 8'h7F);
    add_call(ACT_SIGNAL, 8'h00);
    settle();

    // top count: signal saturates
    set_initial_count(INIT_W'(32767));
    add_call(ACT_CLOSE, 8'h00);
    add_call(ACT_SIGNAL, 8'hFF);
    add_call(ACT_WAIT, 8'h0F);
    add_call(ACT_SIGNAL, 8'hF0);
    add_call(ACT_SIGNAL, 8'h3C);
    add_call(ACT_CLOSE, 8'hC3);
    settle();

    set_initial_count(INIT_W'(3));
    add_call(ACT_CLOSE, any_tid());
    queue_random_calls(25);
    settle();

    send_idle_pct = 79;
    recv_idle_pct = 19;
    set_initial_count(INIT_W'($urandom_range(0, 40)));
    add_call(ACT_CLOSE, any_tid());
    queue_random_calls(25);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_initial_count('0);
    add_call(ACT_CLOSE, any_tid());
    queue_random_calls(25);
    settle();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("fifo_counting_semaphore verification clean");
    end else begin
      $display("fifo_counting_semaphore verification failed");
    end
    $finish;
  end

endmodule

// ===== fifo_counting_semaphore.f =====
+incdir+rtl/core
rtl/core/fcs_pkg.sv
rtl/core/fifo_counting_semaphore.sv
test/tb_fifo_counting_semaphore.sv
